FILE: hdl/dte_pkg.sv
// ----------------------------------------------------------------------------
// dte_pkg
// Shared constants, status codes and controller/datapath interface types
// for the dictionary token expander.
// ----------------------------------------------------------------------------
package dte_pkg;

  localparam int DICT_BYTES    = 4096;
  localparam int MAX_TOKEN_LEN = 64;
  localparam int TABLE_ENTRIES = 256;

  localparam int DICT_AW = $clog2(DICT_BYTES);
  localparam int PTR_W   = DICT_AW + 1;
  localparam int LEN_W   = $clog2(MAX_TOKEN_LEN + 1);
  localparam int TAB_AW  = $clog2(TABLE_ENTRIES);
  localparam int TAB_W   = DICT_AW + LEN_W;

  localparam logic [7:0] MAX_COUNT = 8'd254;
  localparam logic [7:0] ESCAPE    = 8'hFF;
  localparam logic [3:0] COUNT_POS = 4'd11;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
  localparam logic [2:0] ST_TOO_MANY  = 3'd2;
  localparam logic [2:0] ST_TRUNC     = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h48;
      2'd1:    r = 8'h42;
      2'd2:    r = 8'h44;
      default: r = 8'h31;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic accept;
    logic load_lit;
    logic tab_cap;
    logic load_tok;
    logic load_empty;
  } dte_cmd_t;

  typedef struct packed {
    logic out_free;
    logic esc_hit;
    logic emit;
    logic tab_zero;
    logic tok_end;
    logic ex_last;
  } dte_stat_t;

endpackage

FILE: hdl/dictionary_token_expander.sv
// ----------------------------------------------------------------------------
// dictionary_token_expander
// Parses a byte container with a token dictionary and expands escaped
// token ids in the payload into their dictionary bytes.
//
//   channel  handshake             payload
//   input    in_valid / in_ready   data_byte, last_byte
//   output   out_valid / out_ready out_byte, byte_valid, run_last,
//                                  stream_end, status
//
// header, dictionary and literal payload bytes: one transfer per cycle
// unless stalled; an escaped token: a table lookup, then a dictionary
// lookup, then one output byte per cycle while the output is free, input
// held off until the token is read out; output register decouples the
// sides; input also stalls while it is full and not being drained
// reset and the transfer marked last_byte return the parser to the header
// ----------------------------------------------------------------------------
module dictionary_token_expander (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       run_last,
  output logic       stream_end,
  output logic [2:0] status
);

  dte_pkg::dte_cmd_t  cmd;
  dte_pkg::dte_stat_t stat;

  dte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_byte (last_byte),
    .stat      (stat),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  dte_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .out_ready  (out_ready),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .stream_end (stream_end),
    .status     (status)
  );

endmodule

FILE: hdl/dte_ram.sv
// ----------------------------------------------------------------------------
// dte_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/dte_ctrl.sv
// ----------------------------------------------------------------------------
// dte_ctrl
// Controller: input handshake and sequencing of token expansion.
// ----------------------------------------------------------------------------
module dte_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                last_byte,
  input  dte_pkg::dte_stat_t  stat,
  output logic                in_ready,
  output dte_pkg::dte_cmd_t   cmd
);

  localparam logic [1:0] S_IN  = 2'd0;
  localparam logic [1:0] S_TAB = 2'd1;
  localparam logic [1:0] S_WR  = 2'd2;
  localparam logic [1:0] S_FIN = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IN) && stat.out_free;
    case (state)
      S_IN: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          if (stat.esc_hit) begin
            state_next = S_TAB;
          end else if (stat.emit || last_byte) begin
            cmd.load_lit = 1'b1;
          end
        end
      end
      S_TAB: begin
        cmd.tab_cap = 1'b1;
        if (!stat.tab_zero) begin
          state_next = S_WR;
        end else if (stat.ex_last) begin
          state_next = S_FIN;
        end else begin
          state_next = S_IN;
        end
      end
      S_WR: begin
        if (stat.out_free) begin
          cmd.load_tok = 1'b1;
          if (stat.tok_end) begin
            state_next = S_IN;
          end
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.load_empty = 1'b1;
          state_next     = S_IN;
        end
      end
      default: begin
        state_next = S_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hdl/dte_dpath.sv
// ----------------------------------------------------------------------------
// dte_dpath
// Datapath: container parser, token tables, dictionary memory and
// output register.
// ----------------------------------------------------------------------------
module dte_dpath (
  input  logic                clk,
  input  logic                rst,
  input  dte_pkg::dte_cmd_t   cmd,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic                out_ready,
  output dte_pkg::dte_stat_t  stat,
  output logic                out_valid,
  output logic [7:0]          out_byte,
  output logic                byte_valid,
  output logic                run_last,
  output logic                stream_end,
  output logic [2:0]          status
);

  localparam int SUM_W = dte_pkg::PTR_W + 1;

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_TLEN    = 3'd1;
  localparam logic [2:0] PH_TDATA   = 3'd2;
  localparam logic [2:0] PH_PSIZE   = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;
  localparam logic [2:0] PH_ERROR   = 3'd6;

  // parser state
  logic [2:0]                   phase, phase_next;
  logic [3:0]                   pos, pos_next;
  logic [7:0]                   lo, lo_next;
  logic [7:0]                   total, total_next;
  logic [7:0]                   idx, idx_next;
  logic [dte_pkg::LEN_W-1:0]    tok_rem, tok_rem_next;
  logic [dte_pkg::PTR_W-1:0]    dwp, dwp_next;
  logic [31:0]                  pay, pay_next;
  logic                         esc, esc_next;
  logic [2:0]                   err, err_next;

  // expansion state
  logic                         ex_last;
  logic [2:0]                   ex_status;
  logic [dte_pkg::DICT_AW-1:0]  tstart;
  logic [dte_pkg::LEN_W-1:0]    tlen;
  logic [dte_pkg::LEN_W-1:0]    cnt;

  // decode
  logic                         emit, esc_hit, tab_we, dict_we;
  logic [15:0]                  len16;
  logic [dte_pkg::LEN_W-1:0]    len_s;
  logic [SUM_W-1:0]             len_sum;
  logic                         len_bad;
  logic [7:0]                   idx_inc;
  logic [31:0]                  pay_dec;
  logic [2:0]                   fin_status;

  // memories
  logic [dte_pkg::TAB_W-1:0]    tab_rdata;
  logic [dte_pkg::DICT_AW-1:0]  tab_rd_start;
  logic [dte_pkg::LEN_W-1:0]    tab_rd_len;
  logic                         dict_re;
  logic [dte_pkg::DICT_AW-1:0]  dict_raddr;
  logic [7:0]                   dict_rdata;
  logic                         tok_end;

  assign len16   = {data_byte, lo};
  assign len_s   = len16[dte_pkg::LEN_W-1:0];
  assign len_sum = {1'b0, dwp} + SUM_W'(len_s);
  assign len_bad = (len16 > 16'(dte_pkg::MAX_TOKEN_LEN)) ||
                   (len_sum > SUM_W'(dte_pkg::DICT_BYTES));
  assign idx_inc = idx + 8'd1;
  assign pay_dec = pay - 32'd1;

  always_comb begin
    phase_next   = phase;
    pos_next     = pos;
    lo_next      = lo;
    total_next   = total;
    idx_next     = idx;
    tok_rem_next = tok_rem;
    dwp_next     = dwp;
    pay_next     = pay;
    esc_next     = esc;
    err_next     = err;
    emit         = 1'b0;
    esc_hit      = 1'b0;
    tab_we       = 1'b0;
    dict_we      = 1'b0;
    case (phase)
      PH_HEADER: begin
        if (pos < 4'd4) begin
          if (data_byte != dte_pkg::magic_byte(pos[1:0])) begin
            err_next   = dte_pkg::ST_BAD_MAGIC;
            phase_next = PH_ERROR;
          end else begin
            pos_next = pos + 4'd1;
          end
        end else if (pos == dte_pkg::COUNT_POS) begin
          lo_next  = data_byte;
          pos_next = pos + 4'd1;
        end else if (pos == dte_pkg::COUNT_POS + 4'd1) begin
          if (len16 > {8'd0, dte_pkg::MAX_COUNT}) begin
            err_next   = dte_pkg::ST_TOO_MANY;
            phase_next = PH_ERROR;
          end else begin
            total_next = lo;
            idx_next   = 8'd0;
            pos_next   = 4'd0;
            pay_next   = 32'd0;
            phase_next = (lo != 8'd0) ? PH_TLEN : PH_PSIZE;
          end
        end else begin
          pos_next = pos + 4'd1;
        end
      end
      PH_TLEN: begin
        if (pos == 4'd0) begin
          lo_next  = data_byte;
          pos_next = 4'd1;
        end else if (len_bad) begin
          err_next   = dte_pkg::ST_OVERFLOW;
          phase_next = PH_ERROR;
        end else begin
          tab_we   = 1'b1;
          pos_next = 4'd0;
          if (len_s == '0) begin
            idx_next = idx_inc;
            if (idx_inc >= total) begin
              phase_next = PH_PSIZE;
              pay_next   = 32'd0;
            end
          end else begin
            tok_rem_next = len_s;
            phase_next   = PH_TDATA;
          end
        end
      end
      PH_TDATA: begin
        dict_we      = 1'b1;
        dwp_next     = dwp + dte_pkg::PTR_W'(1);
        tok_rem_next = tok_rem - dte_pkg::LEN_W'(1);
        if (tok_rem == dte_pkg::LEN_W'(1)) begin
          idx_next = idx_inc;
          pos_next = 4'd0;
          if (idx_inc >= total) begin
            phase_next = PH_PSIZE;
            pay_next   = 32'd0;
          end else begin
            phase_next = PH_TLEN;
          end
        end
      end
      PH_PSIZE: begin
        pay_next = pay | (32'(data_byte) << {pos[1:0], 3'b000});
        pos_next = pos + 4'd1;
        if (pos[1:0] == 2'd3) begin
          pos_next   = 4'd0;
          esc_next   = 1'b0;
          phase_next = (pay_next != 32'd0) ? PH_PAYLOAD : PH_DONE;
        end
      end
      PH_PAYLOAD: begin
        pay_next = pay_dec;
        if (esc) begin
          esc_next = 1'b0;
          esc_hit  = (data_byte < total);
        end else if (data_byte == dte_pkg::ESCAPE) begin
          esc_next = 1'b1;
        end else begin
          emit = 1'b1;
        end
        if (pay_dec == 32'd0) begin
          esc_next   = 1'b0;
          phase_next = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    if (err_next != dte_pkg::ST_OK) begin
      fin_status = err_next;
    end else if (phase_next != PH_DONE && phase_next != PH_ERROR) begin
      fin_status = dte_pkg::ST_TRUNC;
    end else begin
      fin_status = dte_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd.accept && last_byte)) begin
      phase   <= PH_HEADER;
      pos     <= 4'd0;
      lo      <= 8'd0;
      total   <= 8'd0;
      idx     <= 8'd0;
      tok_rem <= '0;
      dwp     <= '0;
      pay     <= 32'd0;
      esc     <= 1'b0;
      err     <= dte_pkg::ST_OK;
    end else if (cmd.accept) begin
      phase   <= phase_next;
      pos     <= pos_next;
      lo      <= lo_next;
      total   <= total_next;
      idx     <= idx_next;
      tok_rem <= tok_rem_next;
      dwp     <= dwp_next;
      pay     <= pay_next;
      esc     <= esc_next;
      err     <= err_next;
    end
  end

  // token tables: start address and length per id
  dte_ram #(
    .WIDTH (dte_pkg::TAB_W),
    .DEPTH (dte_pkg::TABLE_ENTRIES)
  ) u_tab_ram (
    .clk   (clk),
    .we    (cmd.accept && tab_we),
    .waddr (idx[dte_pkg::TAB_AW-1:0]),
    .wdata ({dwp[dte_pkg::DICT_AW-1:0], len_s}),
    .re    (cmd.accept && esc_hit),
    .raddr (data_byte[dte_pkg::TAB_AW-1:0]),
    .rdata (tab_rdata)
  );

  assign tab_rd_start = tab_rdata[dte_pkg::TAB_W-1:dte_pkg::LEN_W];
  assign tab_rd_len   = tab_rdata[dte_pkg::LEN_W-1:0];
  assign tok_end      = (cnt == tlen);

  assign dict_re    = (cmd.tab_cap && (tab_rd_len != '0)) || (cmd.load_tok && !tok_end);
  assign dict_raddr = cmd.tab_cap ? tab_rd_start : tstart + dte_pkg::DICT_AW'(cnt);

  dte_ram #(
    .WIDTH (8),
    .DEPTH (dte_pkg::DICT_BYTES)
  ) u_dict_ram (
    .clk   (clk),
    .we    (cmd.accept && dict_we),
    .waddr (dwp[dte_pkg::DICT_AW-1:0]),
    .wdata (data_byte),
    .re    (dict_re),
    .raddr (dict_raddr),
    .rdata (dict_rdata)
  );

  // expansion bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ex_last   <= last_byte;
      ex_status <= fin_status;
    end
    if (cmd.tab_cap) begin
      tstart <= tab_rd_start;
      tlen   <= tab_rd_len;
      cnt    <= dte_pkg::LEN_W'(1);
    end else if (cmd.load_tok && !tok_end) begin
      cnt <= cnt + dte_pkg::LEN_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_lit || cmd.load_tok || cmd.load_empty) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_lit) begin
      out_byte   <= emit ? data_byte : 8'd0;
      byte_valid <= emit;
      run_last   <= 1'b1;
      stream_end <= last_byte;
      status     <= last_byte ? fin_status : dte_pkg::ST_OK;
    end else if (cmd.load_tok) begin
      out_byte   <= dict_rdata;
      byte_valid <= 1'b1;
      run_last   <= tok_end;
      stream_end <= tok_end && ex_last;
      status     <= (tok_end && ex_last) ? ex_status : dte_pkg::ST_OK;
    end else if (cmd.load_empty) begin
      out_byte   <= 8'd0;
      byte_valid <= 1'b0;
      run_last   <= 1'b1;
      stream_end <= 1'b1;
      status     <= ex_status;
    end
  end

  assign stat.out_free = !out_valid || out_ready;
  assign stat.esc_hit  = esc_hit;
  assign stat.emit     = emit;
  assign stat.tab_zero = (tab_rd_len == '0);
  assign stat.tok_end  = tok_end;
  assign stat.ex_last  = ex_last;

endmodule
